FILE: src/vdwd_pkg.sv
// Shared types and constants for the varint delta word decoder.
package vdwd_pkg;

    localparam int unsigned VALUE_W  = 24;
    localparam int unsigned PART_W   = 14;
    localparam int unsigned CODE_W   = 20;
    localparam int unsigned LETTER_W = 7;
    localparam int unsigned GROUP_W  = 5;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd65;

    // Outcome of one byte through the gap decoder.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] value;
    } t_dec_out;

    function automatic logic [LETTER_W-1:0] to_letter(input logic [GROUP_W-1:0] grp);
        to_letter = {2'b00, grp} + LETTER_BASE;
    endfunction

endpackage

FILE: src/vdwd_decode.sv
// Gap code assembly and running word value accumulation.
module vdwd_decode
    import vdwd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic           i_start,
    input  logic [7:0]     i_byte,
    output t_dec_out       o_dec
);

    logic [VALUE_W-1:0] r_run;
    logic [PART_W-1:0]  r_part;
    logic [1:0]         r_pos;

    logic [VALUE_W-1:0] w_run;
    logic [PART_W-1:0]  w_part;
    logic [1:0]         w_pos;
    logic [21:0]        w_gap;
    logic               w_done;
    logic [1:0]         w_next_pos;

    // A start flag acts as though the state were cleared before this byte.
    assign w_run  = i_start ? '0 : r_run;
    assign w_part = i_start ? '0 : r_part;
    assign w_pos  = i_start ? POS_FIRST : r_pos;

    always_comb begin
        w_gap      = '0;
        w_done     = 1'b0;
        w_next_pos = POS_FIRST;
        case (w_pos)
            POS_SECOND: begin
                w_gap      = {8'd0, w_part | {i_byte[6:0], 7'd0}};
                w_done     = i_byte[7];
                w_next_pos = POS_THIRD;
            end
            POS_THIRD: begin
                w_gap  = {i_byte, w_part};
                w_done = 1'b1;
            end
            default: begin
                w_gap      = {15'd0, i_byte[6:0]};
                w_done     = i_byte[7];
                w_next_pos = POS_SECOND;
            end
        endcase
    end

    assign o_dec.done  = w_done;
    assign o_dec.value = w_run + {2'b00, w_gap} + VALUE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_part <= '0;
            r_pos  <= POS_FIRST;
        end else if (i_step) begin
            if (w_done) begin
                r_run  <= o_dec.value;
                r_part <= '0;
                r_pos  <= POS_FIRST;
            end else begin
                r_run  <= w_run;
                r_part <= w_gap[PART_W-1:0];
                r_pos  <= w_next_pos;
            end
        end
    end

endmodule

FILE: src/vdwd_format.sv
// Result register that spells the word code as four ASCII letters behind a given first letter.
module vdwd_format
    import vdwd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_take,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [4:0]          i_first_letter,
    output logic                o_valid,
    output logic [55:0]         o_data
);

    logic                r_valid;
    logic [55:0]         r_data;
    logic [CODE_W-1:0]   w_code;
    logic [55:0]         n_data;

    assign w_code = i_value[CODE_W-1:0];
    assign n_data = {1'b0,
                     to_letter(w_code[4:0]),
                     to_letter(w_code[9:5]),
                     to_letter(w_code[14:10]),
                     to_letter(w_code[19:15]),
                     to_letter(i_first_letter),
                     w_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: src/varint_delta_word_decoder.sv
// Top level of the varint delta word decoder.
// Takes one byte request per cycle and presents a result once the byte that ends a gap code
// has passed the input register and been loaded into the result register, and holds it there
// while the result side stalls; bytes that do not end a code give no result. A byte goes into
// an input register, and the decode adder and letter split sit between it and the result
// register, so a new byte is taken every cycle as long as the result side is not stalled with
// a result waiting. A set start flag clears the running value and any partial code first.
module varint_delta_word_decoder
    import vdwd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [4:0] first_letter, [12:5] data_byte, zero above
    input  logic        i_s_axis_tuser,  // [0] start_list
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata   // [19:0] word_code, [26:20] letter_one,
                                         // [33:27] letter_two, [40:34] letter_three,
                                         // [47:41] letter_four, [54:48] letter_five, zero above
);

    logic       r_in_valid;
    logic       r_start;
    logic [4:0] r_letter;
    logic [7:0] r_byte;
    logic       w_adv;
    t_dec_out   w_dec;

    // The held byte moves on once the result register is free or being emptied.
    assign w_adv           = r_in_valid && (!o_m_axis_tvalid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_start  <= i_s_axis_tuser;
            r_letter <= i_s_axis_tdata[4:0];
            r_byte   <= i_s_axis_tdata[12:5];
        end
    end

    vdwd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_start (r_start),
        .i_byte  (r_byte),
        .o_dec   (w_dec)
    );

    vdwd_format u_format (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_adv && w_dec.done),
        .i_take         (i_m_axis_tready),
        .i_value        (w_dec.value),
        .i_first_letter (r_letter),
        .o_valid        (o_m_axis_tvalid),
        .o_data         (o_m_axis_tdata)
    );

    a_held_byte_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_byte) && $stable(r_start))
        else $error("held input byte changed while stalled");

    a_result_from_code_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_adv && w_dec.done))
        else $error("result appeared without a finished gap code");

    a_letters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[55] == 1'b0) &&
            (o_m_axis_tdata[33:27] >= LETTER_BASE) && (o_m_axis_tdata[54:48] >= LETTER_BASE))
        else $error("result letters out of range");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the varint delta word decoder: directed table, then random gap codes.
module tb;
    import vdwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [CODE_W-1:0]   word_code;
        logic [LETTER_W-1:0] letter_one;
        logic [LETTER_W-1:0] letter_two;
        logic [LETTER_W-1:0] letter_three;
        logic [LETTER_W-1:0] letter_four;
        logic [LETTER_W-1:0] letter_five;
    } t_word;

    typedef struct {
        bit                  start_list;
        logic [4:0]          first_letter;
        logic [7:0]          data_byte;
        bit                  typed;
        t_word               word;
    } t_byte_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;   // [4:0] first_letter, [12:5] data_byte, zero above
    logic        i_s_axis_tuser = 1'b0; // [0] start_list
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;        // [19:0] word_code, [26:20] letter_one,
                                        // [33:27] letter_two, [40:34] letter_three,
                                        // [47:41] letter_four, [54:48] letter_five

    // Decoder state as the testbench sees it.
    logic [VALUE_W-1:0] word_value;
    logic [PART_W-1:0]  gap_bits;
    logic [1:0]         code_pos;

    t_word       pending_words[$];
    int unsigned failures;
    int unsigned bytes_sent;
    int unsigned words_checked;
    int unsigned list_starts;
    bit          tx_gaps;
    bit          rx_stalls;
    int unsigned rx_hold;

    varint_delta_word_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [LETTER_W-1:0] ascii_of(input logic [GROUP_W-1:0] grp);
        return LETTER_W'(grp) + LETTER_BASE;
    endfunction

    // Advances the decoder state by one byte; returns 1 when the byte ends a gap code.
    function automatic bit decode_gap_byte(input bit start, input logic [4:0] letter,
                                           input logic [7:0] b, output t_word w);
        logic [VALUE_W-1:0] gap;
        logic [PART_W-1:0]  low_gap;
        bit                 ends;
        ends = 1'b0;
        w = '{default: '0};
        if (start) begin
            word_value = '0;
            gap_bits   = '0;
            code_pos   = POS_FIRST;
        end
        case (code_pos)
            POS_SECOND: begin
                low_gap = gap_bits | {b[6:0], 7'b0};
                gap     = VALUE_W'(low_gap);
                if (b[7]) begin
                    ends = 1'b1;
                end else begin
                    gap_bits = low_gap;
                    code_pos = POS_THIRD;
                end
            end
            POS_THIRD: begin
                gap  = {2'b00, b, gap_bits};
                ends = 1'b1;
            end
            default: begin
                gap = VALUE_W'(b[6:0]);
                if (b[7]) begin
                    ends = 1'b1;
                end else begin
                    gap_bits = PART_W'(b[6:0]);
                    code_pos = POS_SECOND;
                end
            end
        endcase
        if (ends) begin
            word_value     = word_value + gap + 1'b1;
            gap_bits       = '0;
            code_pos       = POS_FIRST;
            w.word_code    = word_value[CODE_W-1:0];
            w.letter_one   = LETTER_W'(letter) + LETTER_BASE;
            w.letter_two   = ascii_of(word_value[19:15]);
            w.letter_three = ascii_of(word_value[14:10]);
            w.letter_four  = ascii_of(word_value[9:5]);
            w.letter_five  = ascii_of(word_value[4:0]);
        end
        return ends;
    endfunction

    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input bit start, input logic [4:0] letter, input logic [7:0] b,
                             input bit typed, input t_word typed_word);
        t_word       w;
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, b, letter};
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (decode_gap_byte(start, letter, b, w))
            pending_words.push_back(typed ? typed_word : w);
        bytes_sent++;
        if (start) list_starts++;
        gap = pick_gap(tx_gaps);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_words();
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [4:0] random_letter();
        if ($urandom_range(0, 99) < 85) return 5'($urandom_range(0, 25));
        return 5'($urandom_range(26, 31));
    endfunction

    // Receiver: ready held for a while, short stalls mostly and a long one now and then.
    always @(posedge i_clk) begin : ready_gen
        int unsigned r;
        if (!rx_stalls) begin
            i_m_axis_tready <= 1'b1;
            rx_hold         <= 0;
        end else if (rx_hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_m_axis_tready <= 1'b1;
                rx_hold         <= $urandom_range(0, 7);
            end else if (r < 93) begin
                i_m_axis_tready <= 1'b0;
                rx_hold         <= $urandom_range(0, 2);
            end else begin
                i_m_axis_tready <= 1'b0;
                rx_hold         <= $urandom_range(15, 40);
            end
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Four-state compare, so an unknown output bit counts as a mismatch.
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("word result 0x%0h with none outstanding", o_m_axis_tdata);
                failures++;
            end else begin
                want = pending_words.pop_front();
                check_field("word_code",    32'(want.word_code),    32'(o_m_axis_tdata[19:0]));
                check_field("letter_one",   32'(want.letter_one),   32'(o_m_axis_tdata[26:20]));
                check_field("letter_two",   32'(want.letter_two),   32'(o_m_axis_tdata[33:27]));
                check_field("letter_three", 32'(want.letter_three), 32'(o_m_axis_tdata[40:34]));
                check_field("letter_four",  32'(want.letter_four),  32'(o_m_axis_tdata[47:41]));
                check_field("letter_five",  32'(want.letter_five),  32'(o_m_axis_tdata[54:48]));
                words_checked++;
            end
        end
    end

    initial begin : stimulus
        t_byte_row   rows[24];
        t_word       none;
        int unsigned code_len;
        int unsigned block;
        logic [7:0]  b;
        none = '{default: '0};
        word_value = '0;
        gap_bits   = '0;
        code_pos   = POS_FIRST;
        failures = 0;
        bytes_sent = 0;
        words_checked = 0;
        list_starts = 0;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;

        // Single-byte codes, two- and three-byte codes, a start in the middle of a code,
        // the all-ones word code, an out-of-range first letter and a wrap of the value.
        rows[0]  = '{1, 5'd0,  8'h80, 1, '{20'd1,       65, 65, 65, 65, 66}};
        rows[1]  = '{0, 5'd25, 8'hFF, 1, '{20'd129,     90, 65, 65, 69, 66}};
        rows[2]  = '{0, 5'd4,  8'h00, 0, none};
        rows[3]  = '{0, 5'd3,  8'hFF, 0, none};
        rows[4]  = '{0, 5'd7,  8'h00, 0, none};
        rows[5]  = '{0, 5'd7,  8'h00, 0, none};
        rows[6]  = '{0, 5'd7,  8'h00, 0, none};
        rows[7]  = '{0, 5'd9,  8'h05, 0, none};
        rows[8]  = '{1, 5'd2,  8'h85, 1, '{20'd6,       67, 65, 65, 65, 71}};
        rows[9]  = '{1, 5'd0,  8'h7E, 0, none};
        rows[10] = '{0, 5'd0,  8'h7F, 0, none};
        rows[11] = '{0, 5'd0,  8'h3F, 1, '{20'hFFFFF,   65, 96, 96, 96, 96}};
        for (int k = 0; k < 4; k++) begin
            rows[12 + 3*k] = '{0, 5'(6*k + 12), 8'h7F, 0, none};
            rows[13 + 3*k] = '{0, 5'(6*k + 12), 8'h7F, 0, none};
            rows[14 + 3*k] = '{0, 5'(6*k + 12), 8'hFF, 0, none};
        end
        // Four maximal gaps add exactly 2^24, so the value wraps back to where it was.
        rows[23] = '{0, 5'd31, 8'hFF, 1, '{20'hFFFFF, 96, 96, 96, 96, 96}};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k])
            send_byte(rows[k].start_list, rows[k].first_letter, rows[k].data_byte,
                      rows[k].typed, rows[k].word);

        // Hold the sender until the directed words are all back.
        i_s_axis_tvalid <= 1'b0;
        drain_words();
        @(posedge i_clk);

        block = 0;
        while (bytes_sent < 900) begin
            if (bytes_sent >= 24 + 100 * block) begin
                block++;
                tx_gaps   = $urandom_range(0, 1);
                rx_stalls = $urandom_range(0, 1);
                if (block == 5) begin
                    i_s_axis_tvalid <= 1'b0;
                    drain_words();
                    @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 99) < 4) begin
                // Noise: a stray byte, possibly restarting the list part-way through a code.
                send_byte($urandom_range(0, 1), 5'($urandom_range(0, 31)),
                          8'($urandom_range(0, 255)), 0, none);
            end else begin
                code_len = $urandom_range(1, 3);
                for (int k = 0; k < code_len; k++) begin
                    if (k == code_len - 1 && code_len == 3)
                        b = 8'($urandom_range(0, 255));
                    else if (k == code_len - 1)
                        b = {1'b1, 7'($urandom_range(0, 127))};
                    else
                        b = {1'b0, 7'($urandom_range(0, 127))};
                    send_byte(k == 0 && $urandom_range(0, 99) < 3, random_letter(), b,
                              0, none);
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        drain_words();
        repeat (8) @(posedge i_clk);
        if (pending_words.size() != 0) failures++;

        $display("tb: %0d bytes sent with %0d list restarts; %0d decoded words compared",
                 bytes_sent, list_starts, words_checked);
        $display("tb: gap codes of one to three bytes, value wrap and stalls on both sides");
        if (failures == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/vdwd_pkg.sv
src/vdwd_decode.sv
src/vdwd_format.sv
src/varint_delta_word_decoder.sv
tb/tb.sv
